### src/prmh_pkg.sv
// Package for the process ready min-heap: sizes, entry and result types,
// status and operation codes, state encoding and the heap ordering function.
// No dependencies.
`default_nettype none

package prmh_pkg;

  // Sizes
  localparam int DEPTH     = 64;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 8;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  // Child index of the deepest node, plus one for the right child
  localparam int KID_BITS  = ADDR_BITS + 2;
  localparam int STAT_BITS = 3;

  // One queued process
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // One result beat
  typedef struct packed {
    status_t              status;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic [CNT_BITS-1:0]  count;
  } res_t;

  // Heap memory access for one cycle
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    entry_t               wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_UP_CHK,
    S_UP_CMP,
    S_RM_LAST,
    S_RM_LOAD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_RESP
  } seq_state_t;

  // True when a must be served before b
  function automatic logic goes_first(entry_t a, entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = (a.prio < b.prio);
    end else begin
      r = (a.id < b.id);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/prmh_ram.sv
// Heap storage: one write port, one read port, registered read data.
// Depends on prmh_pkg.
`default_nettype none

module prmh_ram (
  input  wire logic               clk,
  input  wire prmh_pkg::ram_req_t req,
  output prmh_pkg::entry_t        rdata
);

  prmh_pkg::entry_t mem [prmh_pkg::DEPTH];
  prmh_pkg::entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/prmh_seq.sv
// Heap sequencer: duplicate scan, sift-up on insert, root removal and
// sift-down, all through the one read and one write port of the heap memory. Holds the entry count.
// Depends on prmh_pkg.
`default_nettype none

module prmh_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_kind,
  input  wire logic [prmh_pkg::ID_BITS-1:0]   in_proc_id,
  input  wire logic [prmh_pkg::PRIO_BITS-1:0] in_prio,
  output prmh_pkg::ram_req_t               ram_req,
  input  wire prmh_pkg::entry_t            ram_rdata,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output prmh_pkg::res_t                   res
);

  localparam int AW = prmh_pkg::ADDR_BITS;
  localparam int CW = prmh_pkg::CNT_BITS;
  localparam int KW = prmh_pkg::KID_BITS;

  // Control registers
  prmh_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 rv_r, rv_nxt;

  // Payload registers
  prmh_pkg::entry_t        ent_r, ent_nxt;
  prmh_pkg::entry_t        kid_r, kid_nxt;
  logic                    has_r_r, has_r_nxt;
  logic [CW-1:0]           scan_r, scan_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  prmh_pkg::status_t       rstat_r, rstat_nxt;
  prmh_pkg::entry_t        rent_r, rent_nxt;

  // Tree index arithmetic
  logic [KW-1:0]    lkid, rkid;
  logic [AW-1:0]    pos_m1, parent;
  logic [CW-1:0]    cnt_m1;
  prmh_pkg::entry_t best;
  logic [AW-1:0]    best_addr;
  logic             scan_issue;

  assign lkid   = KW'({pos_r, 1'b1});
  assign rkid   = lkid + KW'(1);
  assign pos_m1 = pos_r - AW'(1);
  assign parent = pos_m1 >> 1;
  assign cnt_m1 = count_r - CW'(1);
  assign scan_issue = (scan_r < count_r);

  // Smaller of the two children during sift-down
  always_comb begin
    if (has_r_r && prmh_pkg::goes_first(ram_rdata, kid_r)) begin
      best      = ram_rdata;
      best_addr = rkid[AW-1:0];
    end else begin
      best      = kid_r;
      best_addr = lkid[AW-1:0];
    end
  end

  // Next state and memory requests
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rv_nxt    = 1'b0;
    ent_nxt   = ent_r;
    kid_nxt   = kid_r;
    has_r_nxt = has_r_r;
    scan_nxt  = scan_r;
    pos_nxt   = pos_r;
    rstat_nxt = rstat_r;
    rent_nxt  = rent_r;
    ram_req   = '0;
    res_valid = 1'b0;
    in_stall  = 1'b1;

    case (state_r)
      prmh_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ent_nxt.id   = in_proc_id;
          ent_nxt.prio = in_prio;
          rent_nxt     = '0;
          scan_nxt     = '0;
          if (prmh_pkg::kind_t'(in_kind) == prmh_pkg::KIND_INSERT) begin
            state_nxt = prmh_pkg::S_SCAN;
          end else if (count_r == '0) begin
            rstat_nxt = prmh_pkg::ST_EMPTY;
            state_nxt = prmh_pkg::S_RESP;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = '0;
            state_nxt     = prmh_pkg::S_RM_LAST;
          end
        end
      end

      // Pipelined ID scan: issue one read a cycle, check the one before
      prmh_pkg::S_SCAN: begin
        if (rv_r && (ram_rdata.id == ent_r.id)) begin
          rstat_nxt = prmh_pkg::ST_DUP;
          state_nxt = prmh_pkg::S_RESP;
        end else if (!rv_r && !scan_issue) begin
          if (count_r == CW'(prmh_pkg::DEPTH)) begin
            rstat_nxt = prmh_pkg::ST_FULL;
            state_nxt = prmh_pkg::S_RESP;
          end else begin
            pos_nxt   = count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
            state_nxt = prmh_pkg::S_UP_CHK;
          end
        end else if (scan_issue) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = scan_r[AW-1:0];
          scan_nxt      = scan_r + CW'(1);
          rv_nxt        = 1'b1;
        end
      end

      // Sift-up: fetch the parent unless at the root
      prmh_pkg::S_UP_CHK: begin
        if (pos_r == '0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = '0;
          ram_req.wdata = ent_r;
          rstat_nxt     = prmh_pkg::ST_INSERTED;
          state_nxt     = prmh_pkg::S_RESP;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = parent;
          state_nxt     = prmh_pkg::S_UP_CMP;
        end
      end

      prmh_pkg::S_UP_CMP: begin
        ram_req.we = 1'b1;
        if (prmh_pkg::goes_first(ent_r, ram_rdata)) begin
          // Parent moves down one level
          ram_req.waddr = pos_r;
          ram_req.wdata = ram_rdata;
          pos_nxt       = parent;
          state_nxt     = prmh_pkg::S_UP_CHK;
        end else begin
          ram_req.waddr = pos_r;
          ram_req.wdata = ent_r;
          rstat_nxt     = prmh_pkg::ST_INSERTED;
          state_nxt     = prmh_pkg::S_RESP;
        end
      end

      // Root arrives; fetch the last entry
      prmh_pkg::S_RM_LAST: begin
        rent_nxt      = ram_rdata;
        rstat_nxt     = prmh_pkg::ST_REMOVED;
        ram_req.re    = 1'b1;
        ram_req.raddr = cnt_m1[AW-1:0];
        count_nxt     = cnt_m1;
        state_nxt     = prmh_pkg::S_RM_LOAD;
      end

      prmh_pkg::S_RM_LOAD: begin
        ent_nxt = ram_rdata;
        pos_nxt = '0;
        if (count_r == '0) begin
          state_nxt = prmh_pkg::S_RESP;
        end else begin
          state_nxt = prmh_pkg::S_DN_RDL;
        end
      end

      // Sift-down: a leaf takes the moving entry, else fetch the left child
      prmh_pkg::S_DN_RDL: begin
        if (lkid >= KW'(count_r)) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = ent_r;
          state_nxt     = prmh_pkg::S_RESP;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = lkid[AW-1:0];
          state_nxt     = prmh_pkg::S_DN_RDR;
        end
      end

      prmh_pkg::S_DN_RDR: begin
        kid_nxt   = ram_rdata;
        has_r_nxt = (rkid < KW'(count_r));
        if (rkid < KW'(count_r)) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rkid[AW-1:0];
        end
        state_nxt = prmh_pkg::S_DN_CMP;
      end

      prmh_pkg::S_DN_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        if (prmh_pkg::goes_first(best, ent_r)) begin
          // Smaller child moves up one level
          ram_req.wdata = best;
          pos_nxt       = best_addr;
          state_nxt     = prmh_pkg::S_DN_RDL;
        end else begin
          ram_req.wdata = ent_r;
          state_nxt     = prmh_pkg::S_RESP;
        end
      end

      prmh_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = prmh_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = prmh_pkg::S_IDLE;
      end
    endcase
  end

  assign res.status = rstat_r;
  assign res.id     = rent_r.id;
  assign res.prio   = rent_r.prio;
  assign res.count  = count_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prmh_pkg::S_IDLE;
      count_r <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rv_r    <= rv_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    kid_r   <= kid_nxt;
    has_r_r <= has_r_nxt;
    scan_r  <= scan_nxt;
    pos_r   <= pos_nxt;
    rstat_r <= rstat_nxt;
    rent_r  <= rent_nxt;
  end

endmodule

`default_nettype wire

### src/prmh_outreg.sv
// Result output register: holds one result beat so the sequencer can take
// the next item while the consumer stalls. Depends on prmh_pkg.
`default_nettype none

module prmh_outreg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           res_valid,
  output logic                                res_ready,
  input  wire prmh_pkg::res_t                 res,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [prmh_pkg::STAT_BITS-1:0]      out_status,
  output logic [prmh_pkg::ID_BITS-1:0]        out_id,
  output logic [prmh_pkg::PRIO_BITS-1:0]      out_prio,
  output logic [prmh_pkg::CNT_BITS-1:0]       out_count
);

  logic           valid_r, valid_nxt;
  prmh_pkg::res_t data_r;
  logic           load;

  // Free when empty or when the held beat leaves this cycle
  assign res_ready = !valid_r || !out_stall;
  assign load      = res_valid && res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = data_r.status;
  assign out_id     = data_r.id;
  assign out_prio   = data_r.prio;
  assign out_count  = data_r.count;

endmodule

`default_nettype wire

### src/process_ready_min_heap_top.sv
// Process ready queue kept as a binary min-heap in one synchronous memory.
// Each item is an insert (ID, priority) or a remove of the entry with the
// lowest priority number, the lower ID winning ties. One item is worked at a
// time; the single read port of the heap memory sets the rate. An insert
// scans every queued ID for a duplicate at one entry per cycle, then sifts
// up, reading the parent and writing one entry per level. A remove reads the
// root and the last entry, then sifts down, reading the children and
// writing one entry per level. The result is then handed to the output
// register, which lets the next item in while a result is stalled.
// No clearing pass: reset clears only the control state and the entry count.
// Depends on prmh_pkg, prmh_seq, prmh_ram and prmh_outreg.
`default_nettype none

module process_ready_min_heap_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_kind,
  input  wire logic [prmh_pkg::ID_BITS-1:0]   in_proc_id,
  input  wire logic [prmh_pkg::PRIO_BITS-1:0] in_prio,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [prmh_pkg::STAT_BITS-1:0]      out_status,
  output logic [prmh_pkg::ID_BITS-1:0]        out_id,
  output logic [prmh_pkg::PRIO_BITS-1:0]      out_prio,
  output logic [prmh_pkg::CNT_BITS-1:0]       out_count
);

  prmh_pkg::ram_req_t ram_req;
  prmh_pkg::entry_t   ram_rdata;
  prmh_pkg::res_t     res;
  logic               res_valid;
  logic               res_ready;

  prmh_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_proc_id (in_proc_id),
    .in_prio    (in_prio),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  prmh_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  prmh_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_id     (out_id),
    .out_prio   (out_prio),
    .out_count  (out_count)
  );

endmodule

`default_nettype wire

### src/prmh_chk.sv
// Port-level checks for the process ready min-heap, bound to the top level.
// Depends on prmh_pkg and process_ready_min_heap_top.
`default_nettype none

module prmh_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           in_kind,
  input wire logic [prmh_pkg::ID_BITS-1:0]   in_proc_id,
  input wire logic [prmh_pkg::PRIO_BITS-1:0] in_prio,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [prmh_pkg::STAT_BITS-1:0] out_status,
  input wire logic [prmh_pkg::ID_BITS-1:0]   out_id,
  input wire logic [prmh_pkg::PRIO_BITS-1:0] out_prio,
  input wire logic [prmh_pkg::CNT_BITS-1:0]  out_count
);

  // One item at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  // Count never passes the heap depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= prmh_pkg::CNT_BITS'(prmh_pkg::DEPTH))
    else $error("result count beyond depth");

  // Only a removal carries an entry
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != prmh_pkg::ST_REMOVED) |->
      (out_id == '0) && (out_prio == '0))
    else $error("entry fields set on a result that is not a removal");

  // Empty and full answers match the count
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == prmh_pkg::ST_EMPTY) ||
                  (out_status == prmh_pkg::ST_FULL)) |->
      ((out_status == prmh_pkg::ST_EMPTY) && (out_count == '0)) ||
      ((out_status == prmh_pkg::ST_FULL) &&
       (out_count == prmh_pkg::CNT_BITS'(prmh_pkg::DEPTH))))
    else $error("empty or full answer with the wrong count");

endmodule

bind process_ready_min_heap_top prmh_chk u_prmh_chk (.*);

`default_nettype wire

### bench/process_ready_min_heap_top_tb.sv
// Self-checking bench for process_ready_min_heap_top: random and directed
// insert/remove beats checked against an in-bench heap predictor.
// Depends on prmh_pkg and the process_ready_min_heap_top RTL.
module process_ready_min_heap_top_tb;
  import prmh_pkg::*;

  localparam int unsigned ITEM_GOAL   = 1150;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 120;

  // Ready-queue predictor plus the queue of results it still expects
  class ready_queue_model;
    entry_t      slot [DEPTH];
    int unsigned fill;
    res_t        pending_results [$];
    int unsigned errors;
    int unsigned worked;
    int unsigned peak;
    int unsigned seen [5];

    function new();
      fill = 0;
      errors = 0;
      worked = 0;
      peak = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    // Lower priority number first, lower ID on a tie
    function bit ahead(entry_t a, entry_t b);
      return (a.prio < b.prio) || ((a.prio == b.prio) && (a.id < b.id));
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      entry_t t;
      t = slot[a];
      slot[a] = slot[b];
      slot[b] = t;
    endfunction

    function logic [ID_BITS-1:0] queued_id();
      return slot[$urandom_range(0, fill - 1)].id;
    endfunction

    // Update the heap for one accepted input beat and queue its result
    function void apply_item(kind_t k, logic [ID_BITS-1:0] pid,
                             logic [PRIO_BITS-1:0] pr);
      res_t        r;
      bit          dup;
      int unsigned pos;
      int unsigned par;
      int unsigned kid;
      int unsigned best;
      r = '0;
      if (k == KIND_INSERT) begin
        dup = 1'b0;
        for (int unsigned i = 0; i < fill; i++) begin
          if (slot[i].id == pid) dup = 1'b1;
        end
        if (dup) begin
          r.status = ST_DUP;
        end else if (fill == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot[fill].id = pid;
          slot[fill].prio = pr;
          pos = fill;
          fill++;
          // sift up
          while (pos > 0) begin
            par = (pos - 1) / 2;
            if (!ahead(slot[pos], slot[par])) break;
            swap_slots(pos, par);
            pos = par;
          end
          r.status = ST_INSERTED;
        end
      end else if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_REMOVED;
        r.id = slot[0].id;
        r.prio = slot[0].prio;
        fill--;
        slot[0] = slot[fill];
        pos = 0;
        // sift down toward the smaller child
        while (1'b1) begin
          kid = 2 * pos + 1;
          best = pos;
          if (kid < fill && ahead(slot[kid], slot[best])) best = kid;
          if (kid + 1 < fill && ahead(slot[kid + 1], slot[best])) best = kid + 1;
          if (best == pos) break;
          swap_slots(pos, best);
          pos = best;
        end
      end
      r.count = CNT_BITS'(fill);
      worked++;
      if (fill > peak) peak = fill;
      pending_results = {pending_results, r};
    endfunction

    // Compare one accepted result beat with the oldest expectation
    function void check_result(logic [STAT_BITS-1:0] st, logic [ID_BITS-1:0] rid,
                               logic [PRIO_BITS-1:0] rpr, logic [CNT_BITS-1:0] cnt);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d id %0h prio %0h count %0d",
               st, rid, rpr, cnt);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      seen[want.status]++;
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (rid !== want.id) begin
        $error("out_id: expected %0h, got %0h", want.id, rid);
        errors++;
      end
      if (rpr !== want.prio) begin
        $error("out_prio: expected %0h, got %0h", want.prio, rpr);
        errors++;
      end
      if (cnt !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 in_kind    = 1'b0;
  logic [ID_BITS-1:0]   in_proc_id = '0;
  logic [PRIO_BITS-1:0] in_prio    = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [STAT_BITS-1:0] out_status;
  logic [ID_BITS-1:0]   out_id;
  logic [PRIO_BITS-1:0] out_prio;
  logic [CNT_BITS-1:0]  out_count;

  ready_queue_model heap_model;
  bit               calm = 1'b0;
  bit               hold_off_req = 1'b0;
  int unsigned      cycles = 0;

  process_ready_min_heap_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_proc_id (in_proc_id),
    .in_prio    (in_prio),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_id     (out_id),
    .out_prio   (out_prio),
    .out_count  (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      heap_model.check_result(out_status, out_id, out_prio, out_count);
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stall spans, plus one long hold-off on request
  initial begin : receiver
    int unsigned span;
    bit          stalling;
    span = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        span = 0;
      end else begin
        if (span == 0) begin
          stalling = !calm && ($urandom_range(0, 99) < 35);
          span = gap_length();
        end
        out_stall <= stalling;
        span--;
      end
    end
  end

  // Offer one beat, wait for it to be taken, then sometimes idle a random gap
  task automatic send_item(kind_t k, logic [ID_BITS-1:0] pid, logic [PRIO_BITS-1:0] pr);
    int unsigned idle;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_kind    <= k;
    in_proc_id <= pid;
    in_prio    <= pr;
    do @(posedge clk); while (in_stall);
    heap_model.apply_item(k, pid, pr);
    idle = (calm || $urandom_range(0, 99) < 55) ? 0 : gap_length();
    if (idle > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
  endtask

  // Sender pause until every expected result beat is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (heap_model.pending_results.size() != 0) @(posedge clk);
  endtask

  // Random beat; IDs sometimes reuse queued or clustered values, priorities often tie
  task automatic random_item(int unsigned insert_pct);
    kind_t                k;
    logic [ID_BITS-1:0]   pid;
    logic [PRIO_BITS-1:0] pr;
    int unsigned          r;
    k = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
    r = $urandom_range(0, 99);
    if (r < 12 && heap_model.fill > 0) begin
      pid = heap_model.queued_id();
    end else if (r < 25) begin
      pid = ($urandom_range(0, 1) != 0) ? ID_BITS'($urandom_range(0, 7))
                                        : ~ID_BITS'($urandom_range(0, 7));
    end else begin
      pid = ID_BITS'($urandom);
    end
    pr = ($urandom_range(0, 99) < 40) ? PRIO_BITS'($urandom_range(0, 3))
                                      : PRIO_BITS'($urandom);
    send_item(k, pid, pr);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned span;
    int unsigned pct;
    heap_model = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty remove, field extremes, priority tie, duplicates, drain
    send_item(KIND_REMOVE, '0, '0);
    send_item(KIND_INSERT, '0, '1);
    send_item(KIND_INSERT, '1, '0);
    send_item(KIND_INSERT, 16'h1234, 8'h80);
    send_item(KIND_INSERT, 16'h0010, 8'h80);
    send_item(KIND_INSERT, '1, 8'h10);
    send_item(KIND_INSERT, '0, '0);
    send_item(KIND_INSERT, 16'hAAAA, 8'h55);
    send_item(KIND_INSERT, 16'h5555, 8'hAA);
    repeat (7) send_item(KIND_REMOVE, '1, '1);
    wait_drained();

    // Random phases: fill to full, drain to empty, then a random mix
    phase = 0;
    while (heap_model.worked < ITEM_GOAL) begin
      case (phase)
        0: begin
          pct = 90;
          span = 160;
        end
        1: begin
          pct = 10;
          span = 160;
        end
        default: begin
          case ($urandom_range(0, 2))
            0: pct = 85;
            1: pct = 15;
            default: pct = 50;
          endcase
          span = $urandom_range(40, 140);
        end
      endcase
      calm = ($urandom_range(0, 3) == 0);
      // long receiver hold-off while the sender keeps offering
      if (phase == 2 || $urandom_range(0, 9) == 0) begin
        calm = 1'b1;
        hold_off_req = 1'b1;
      end
      for (int unsigned n = 0; n < span && heap_model.worked < ITEM_GOAL; n++) begin
        random_item(pct);
      end
      calm = 1'b0;
      if (phase == 0 || $urandom_range(0, 2) == 0) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (heap_model.pending_results.size() != 0) begin
      $error("%0d expected result beats never arrived",
             heap_model.pending_results.size());
      heap_model.errors++;
    end

    $display("Covered %0d inserts, %0d removes, %0d duplicate inserts, %0d full inserts,",
             heap_model.seen[ST_INSERTED], heap_model.seen[ST_REMOVED],
             heap_model.seen[ST_DUP], heap_model.seen[ST_FULL]);
    $display("%0d empty removes over %0d phases; peak occupancy %0d of %0d, %0d mismatches.",
             heap_model.seen[ST_EMPTY], phase, heap_model.peak, DEPTH, heap_model.errors);
    if (heap_model.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
